// ===== hdl/rrt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrt_pkg - shared types and constants for the received range tracker
// Word layouts of both channels, table sizing default and sequencer states.
// ----------------------------------------------------------------------------
package rrt_pkg;

    localparam int SEQ_W          = 63;
    localparam int MAX_RANGES_DEF = 16;

    typedef struct packed {
        logic [SEQ_W-1:0] range_start;
        logic [SEQ_W-1:0] range_end;
    } rrt_in_t;

    typedef struct packed {
        logic [SEQ_W-1:0] entry_start;
        logic [SEQ_W-1:0] entry_end;
        logic             entry_valid;
        logic             last_entry;
        logic             overflow;
        logic             bad_range;
    } rrt_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_FIN,
        ST_EMIT
    } rrt_state_t;

endpackage

// ===== hdl/rrt_in_if.sv =====
// ----------------------------------------------------------------------------
// rrt_in_if - range word channel
// Valid/ready channel carrying one range to add.
// ----------------------------------------------------------------------------
interface rrt_in_if;
    import rrt_pkg::*;

    logic    valid;
    logic    ready;
    rrt_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rrt_out_if.sv =====
// ----------------------------------------------------------------------------
// rrt_out_if - table entry channel
// Valid/ready channel carrying one stored range and its status flags.
// ----------------------------------------------------------------------------
interface rrt_out_if;
    import rrt_pkg::*;

    logic     valid;
    logic     ready;
    rrt_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rrt_ram.sv =====
// ----------------------------------------------------------------------------
// rrt_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/received_range_tracker.sv =====
// A range word is taken only in ST_IDLE, so the next one waits until the whole table has
//   been streamed out; the single RAM read port walks the live table in the merge pass
//   and again while streaming it.
// Reset: rst_n clears the range count and the sequencer; table contents stay undefined
//   and are never read before being written, so there is no clearing pass.
// ----------------------------------------------------------------------------
// received_range_tracker - sorted table of received sequence number ranges
// Merges each new range into a table of disjoint, non-touching ranges and
// streams the whole table out after every range word.
// ----------------------------------------------------------------------------
module received_range_tracker #(
    parameter int MAX_RANGES = rrt_pkg::MAX_RANGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rrt_in_if.sink       ranges,
    rrt_out_if.source    entries
);
    import rrt_pkg::*;

    // Table lives in one RAM split in two banks: the merge pass reads the
    // live bank and writes the updated table into the other one, which then
    // becomes live. On overflow the bank is simply not swapped.
    localparam int IDX_W     = $clog2(MAX_RANGES);
    localparam int CNT_W     = $clog2(MAX_RANGES + 1);
    localparam int RAM_AW    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;
    localparam int RAM_W     = 2 * SEQ_W;

    rrt_state_t state_reg, state_next;

    logic             bank_reg,    bank_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [CNT_W-1:0] rd_idx_reg,  rd_idx_next;   // next entry to read in merge
    logic [CNT_W-1:0] proc_idx_reg, proc_idx_next; // entries processed in merge
    logic [CNT_W-1:0] widx_reg,    widx_next;     // write slot in spare bank
    logic [CNT_W-1:0] em_idx_reg,  em_idx_next;   // entry being presented
    logic             dv_reg,      dv_next;       // RAM read data valid
    logic             placed_reg,  placed_next;
    logic             merged_reg,  merged_next;
    logic             ovf_reg,     ovf_next;
    logic             bad_reg,     bad_next;

    // working range and the entry held back once the new range is placed
    logic [SEQ_W-1:0] s_reg, s_next;
    logic [SEQ_W-1:0] e_reg, e_next;
    logic [SEQ_W-1:0] pend_s_reg, pend_s_next;
    logic [SEQ_W-1:0] pend_e_reg, pend_e_next;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [RAM_W-1:0]  ram_wdata;
    logic [RAM_AW-1:0] ram_raddr;
    logic [RAM_W-1:0]  ram_rdata;

    logic [SEQ_W-1:0] rd_s;
    logic [SEQ_W-1:0] rd_e;
    logic             is_before;
    logic             is_after;
    logic             issue;
    logic             fire;
    logic             last;
    logic [CNT_W-1:0] em_idx_inc;
    logic [CNT_W-1:0] addr_idx;

    rrt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_s = ram_rdata[RAM_W-1:SEQ_W];
    assign rd_e = ram_rdata[SEQ_W-1:0];

    // Entry lies wholly below the working range with a gap (end+1 < start),
    // or wholly above with a gap (start > end+1); anything else merges.
    // Compared in 64 bits so the +1 cannot wrap.
    assign is_before = (({1'b0, rd_e} + 64'd1) < {1'b0, s_reg});
    assign is_after  = ({1'b0, rd_s} > ({1'b0, e_reg} + 64'd1));

    assign em_idx_inc = em_idx_reg + CNT_W'(1);
    assign fire       = entries.valid && entries.ready;
    assign last       = (count_reg == '0) || (em_idx_inc == count_reg);

    always_comb
    begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        proc_idx_next = proc_idx_reg;
        widx_next     = widx_reg;
        em_idx_next   = em_idx_reg;
        dv_next       = dv_reg;
        placed_next   = placed_reg;
        merged_next   = merged_reg;
        ovf_next      = ovf_reg;
        bad_next      = bad_reg;
        s_next        = s_reg;
        e_next        = e_reg;
        pend_s_next   = pend_s_reg;
        pend_e_next   = pend_e_reg;

        issue     = 1'b0;
        addr_idx  = rd_idx_reg;
        ram_we    = 1'b0;
        ram_waddr = {~bank_reg, widx_reg[IDX_W-1:0]};
        ram_wdata = {s_reg, e_reg};
        ram_raddr = {bank_reg, rd_idx_reg[IDX_W-1:0]};

        ranges.ready = 1'b0;

        entries.valid            = 1'b0;
        entries.data.entry_valid = (count_reg != '0);
        entries.data.entry_start = (count_reg != '0) ? rd_s : '0;
        entries.data.entry_end   = (count_reg != '0) ? rd_e : '0;
        entries.data.last_entry  = last;
        entries.data.overflow    = ovf_reg;
        entries.data.bad_range   = bad_reg;

        case (state_reg)
            ST_IDLE:
            begin
                ranges.ready = 1'b1;
                if (ranges.valid)
                begin
                    s_next        = ranges.data.range_start;
                    e_next        = ranges.data.range_end;
                    placed_next   = 1'b0;
                    merged_next   = 1'b0;
                    rd_idx_next   = '0;
                    proc_idx_next = '0;
                    widx_next     = '0;
                    em_idx_next   = '0;
                    dv_next       = 1'b0;
                    ovf_next      = 1'b0;
                    if (ranges.data.range_end < ranges.data.range_start)
                    begin
                        // reversed: table untouched, just stream it
                        bad_next   = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = (count_reg == '0) ? ST_FIN : ST_MERGE;
                    end
                end
            end

            ST_MERGE:
            begin
                // read runs one entry ahead of the compare
                issue = (rd_idx_reg < count_reg);
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                dv_next = issue;

                if (dv_reg)
                begin
                    proc_idx_next = proc_idx_reg + CNT_W'(1);
                    if (is_before)
                    begin
                        ram_we    = (widx_reg < CNT_W'(MAX_RANGES));
                        ram_wdata = {rd_s, rd_e};
                        widx_next = widx_reg + CNT_W'(1);
                    end
                    else if (is_after)
                    begin
                        // first entry above: place the working range, then
                        // every later entry is written one step behind
                        ram_we      = (widx_reg < CNT_W'(MAX_RANGES));
                        ram_wdata   = placed_reg ? {pend_s_reg, pend_e_reg}
                                                 : {s_reg, e_reg};
                        widx_next   = widx_reg + CNT_W'(1);
                        pend_s_next = rd_s;
                        pend_e_next = rd_e;
                        placed_next = 1'b1;
                    end
                    else
                    begin
                        if (rd_s < s_reg)
                        begin
                            s_next = rd_s;
                        end
                        if (rd_e > e_reg)
                        begin
                            e_next = rd_e;
                        end
                        merged_next = 1'b1;
                    end
                    if (proc_idx_next == count_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                // flush the last word of the new table
                ram_we    = (widx_reg < CNT_W'(MAX_RANGES));
                ram_wdata = placed_reg ? {pend_s_reg, pend_e_reg} : {s_reg, e_reg};
                if (!merged_reg && (count_reg >= CNT_W'(MAX_RANGES)))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    bank_next  = ~bank_reg;
                    count_next = widx_reg + CNT_W'(1);
                end
                em_idx_next = '0;
                dv_next     = 1'b0;
                state_next  = ST_EMIT;
            end

            ST_EMIT:
            begin
                // RAM output register is the output stage: the address holds
                // while stalled and steps ahead on every accepted word
                entries.valid = dv_reg;
                dv_next       = 1'b1;
                addr_idx      = fire ? em_idx_inc : em_idx_reg;
                ram_raddr     = {bank_reg, addr_idx[IDX_W-1:0]};
                if (fire)
                begin
                    if (last)
                    begin
                        dv_next    = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        em_idx_next = em_idx_inc;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bank_reg     <= 1'b0;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            proc_idx_reg <= '0;
            widx_reg     <= '0;
            em_idx_reg   <= '0;
            dv_reg       <= 1'b0;
            placed_reg   <= 1'b0;
            merged_reg   <= 1'b0;
            ovf_reg      <= 1'b0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            proc_idx_reg <= proc_idx_next;
            widx_reg     <= widx_next;
            em_idx_reg   <= em_idx_next;
            dv_reg       <= dv_next;
            placed_reg   <= placed_next;
            merged_reg   <= merged_next;
            ovf_reg      <= ovf_next;
            bad_reg      <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        e_reg      <= e_next;
        pend_s_reg <= pend_s_next;
        pend_e_reg <= pend_e_next;
    end

endmodule

// ===== tb/sv/received_range_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// received_range_tracker_tb - self-checking bench for the range tracker
// Feeds range words through the valid/ready channel, keeps its own copy of
// the sorted range table, and checks every streamed entry word in order.
// Sender and sink pacing change between phases; one long sink stall fills
// the block, and sender pauses let the table dump drain completely.
// ----------------------------------------------------------------------------
module received_range_tracker_tb;
    import rrt_pkg::*;

    localparam int TABLE_DEPTH    = MAX_RANGES_DEF;
    localparam int DIRECTED_WORDS = 25;
    localparam int RANDOM_WORDS   = 200;
    localparam int WINDOW         = 40;     // span of one random cluster
    localparam int LONG_STALL     = 400;    // sink hold-off, in cycles
    localparam int STALL_AFTER    = 4;      // words into the last phase before it
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
    localparam int TAIL_CYCLES    = 48;     // idle tail before the verdict
    localparam int MAX_SHOWN      = 10;

    localparam logic [SEQ_W-1:0] SEQ_TOP = {SEQ_W{1'b1}};

    // One stimulus word; wait_drain holds it back until every entry word
    // owed so far has been seen.
    typedef struct packed {
        rrt_in_t word;
        logic    wait_drain;
    } range_job_t;

    logic clk = 1'b0;
    logic rst_n;

    rrt_in_if  ranges_ch ();
    rrt_out_if entries_ch ();

    received_range_tracker #(
        .MAX_RANGES (TABLE_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .ranges  (ranges_ch),
        .entries (entries_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------------
    range_job_t       stimulus [$];
    rrt_out_t         expected_q [$];      // entry words still owed by the block

    // Bench copy of the range table
    logic [SEQ_W-1:0] tbl_lo [TABLE_DEPTH];
    logic [SEQ_W-1:0] tbl_hi [TABLE_DEPTH];
    int               tbl_count   = 0;
    int               tbl_peak    = 0;

    int               n_reversed  = 0;
    int               n_dropped   = 0;
    int               n_merged    = 0;
    int               mismatch_count = 0;

    int               words_sent;
    int               entries_seen;
    int               stage;               // 0, 1, 2: pacing phase
    int               phase1_at;
    int               phase2_at;
    int               total_words;
    int               stall_left;
    logic             stall_done;
    int               quiet_cycles = 0;
    range_job_t       next_job;
    rrt_out_t         want;

    // Idle percentage per phase: sender 21/52/0, sink 52/21/0.
    function automatic int idle_pct(int st, logic sink_side);
        case (st)
            0:       return sink_side ? 52 : 21;
            1:       return sink_side ? 21 : 52;
            default: return 0;
        endcase
    endfunction

    function automatic void add_word(logic [SEQ_W-1:0] s, logic [SEQ_W-1:0] e);
        range_job_t j;
        j.word.range_start = s;
        j.word.range_end   = e;
        j.wait_drain       = 1'b0;
        stimulus = {stimulus, j};
    endfunction

    // Queue the table dump owed after one range word.
    function automatic void dump_table(logic ovf, logic bad);
        rrt_out_t e;
        int       i;
        e           = '0;
        e.overflow  = ovf;
        e.bad_range = bad;
        if (tbl_count == 0)
        begin
            // empty table still gives one word, marked as not carrying a range
            e.last_entry = 1'b1;
            expected_q = {expected_q, e};
        end
        else
        begin
            for (i = 0; i < tbl_count; i++)
            begin
                e.entry_start = tbl_lo[i];
                e.entry_end   = tbl_hi[i];
                e.entry_valid = 1'b1;
                e.last_entry  = (i == tbl_count - 1);
                expected_q = {expected_q, e};
            end
        end
    endfunction

    // Fold one range into the table: everything it overlaps or abuts
    // (start one above a stored end, or the reverse) collapses into it.
    function automatic void merge_range(rrt_in_t w);
        logic [SEQ_W:0]   lo;
        logic [SEQ_W:0]   hi;
        logic [SEQ_W:0]   a;
        logic [SEQ_W:0]   b;
        logic [SEQ_W-1:0] new_lo [$];
        logic [SEQ_W-1:0] new_hi [$];
        int               joined;
        logic             placed;
        int               i;
        lo     = {1'b0, w.range_start};
        hi     = {1'b0, w.range_end};
        joined = 0;
        placed = 1'b0;
        if (hi < lo)
        begin
            n_reversed++;
            dump_table(1'b0, 1'b1);
            return;
        end
        // one extra bit on the compare side so +1 on the top value cannot wrap
        for (i = 0; i < tbl_count; i++)
        begin
            a = {1'b0, tbl_lo[i]};
            b = {1'b0, tbl_hi[i]};
            if (b + 1'b1 < lo)
            begin
                new_lo = {new_lo, a[SEQ_W-1:0]};
                new_hi = {new_hi, b[SEQ_W-1:0]};
            end
            else if (a > hi + 1'b1)
            begin
                if (!placed)
                begin
                    new_lo = {new_lo, lo[SEQ_W-1:0]};
                    new_hi = {new_hi, hi[SEQ_W-1:0]};
                    placed = 1'b1;
                end
                new_lo = {new_lo, a[SEQ_W-1:0]};
                new_hi = {new_hi, b[SEQ_W-1:0]};
            end
            else
            begin
                if (a < lo)
                    lo = a;
                if (b > hi)
                    hi = b;
                joined++;
            end
        end
        if (!placed)
        begin
            new_lo = {new_lo, lo[SEQ_W-1:0]};
            new_hi = {new_hi, hi[SEQ_W-1:0]};
        end
        // full table and nothing to absorb into: drop, table untouched
        if (joined == 0 && tbl_count >= TABLE_DEPTH)
        begin
            n_dropped++;
            dump_table(1'b1, 1'b0);
            return;
        end
        if (joined != 0)
            n_merged++;
        for (i = 0; i < new_lo.size(); i++)
        begin
            tbl_lo[i] = new_lo[i];
            tbl_hi[i] = new_hi[i];
        end
        tbl_count = new_lo.size();
        if (tbl_count > tbl_peak)
            tbl_peak = tbl_count;
        dump_table(1'b0, 1'b0);
    endfunction

    function automatic void check_field(string field, logic [SEQ_W-1:0] exp_v,
                                        logic [SEQ_W-1:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
                $display("%0t: entry word %0d, %s expected %0h, got %0h",
                         $time, entries_seen, field, exp_v, got_v);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: takes range words off the stimulus queue. A word on offer
    // stays put until accepted; the table model is updated at acceptance.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ranges_ch.valid <= 1'b0;
            ranges_ch.data  <= '0;
            words_sent      <= 0;
            stage           <= 0;
        end
        else
        begin
            if (ranges_ch.valid && ranges_ch.ready)
            begin
                merge_range(ranges_ch.data);
                words_sent <= words_sent + 1;
                stage      <= (words_sent + 1 >= phase2_at) ? 2 :
                              (words_sent + 1 >= phase1_at) ? 1 : 0;
            end
            if (!ranges_ch.valid || ranges_ch.ready)
            begin
                if (stimulus.size() != 0
                    && !(stimulus[0].wait_drain && expected_q.size() != 0)
                    && $urandom_range(99) >= idle_pct(stage, 1'b0))
                begin
                    next_job = stimulus.pop_front();
                    ranges_ch.valid <= 1'b1;
                    ranges_ch.data  <= next_job.word;
                end
                else
                    ranges_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink pacing. STALL_AFTER words into the last phase the sink holds off
    // for the LONG_STALL hold-off while the sender keeps offering, so the block
    // backs up and has to stall its input.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_ch.ready <= 1'b0;
            stall_left       <= 0;
            stall_done       <= 1'b0;
        end
        else if (stage == 2 && !stall_done && words_sent >= phase2_at + STALL_AFTER)
        begin
            entries_ch.ready <= 1'b0;
            stall_left       <= LONG_STALL - 1;
            stall_done       <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            entries_ch.ready <= 1'b0;
            stall_left       <= stall_left - 1;
        end
        else
            entries_ch.ready <= ($urandom_range(99) >= idle_pct(stage, 1'b1));
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted entry word against the oldest one owed.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entries_seen <= 0;
        else if (entries_ch.valid && entries_ch.ready)
        begin
            entries_seen <= entries_seen + 1;
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("%0t: unexpected entry word %0d: start %0h end %0h",
                             $time, entries_seen, entries_ch.data.entry_start,
                             entries_ch.data.entry_end);
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("entry_start", want.entry_start, entries_ch.data.entry_start);
                check_field("entry_end", want.entry_end, entries_ch.data.entry_end);
                check_field("entry_valid", SEQ_W'(want.entry_valid),
                            SEQ_W'(entries_ch.data.entry_valid));
                check_field("last_entry", SEQ_W'(want.last_entry),
                            SEQ_W'(entries_ch.data.last_entry));
                check_field("overflow", SEQ_W'(want.overflow),
                            SEQ_W'(entries_ch.data.overflow));
                check_field("bad_range", SEQ_W'(want.bad_range),
                            SEQ_W'(entries_ch.data.bad_range));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any handshake on either channel.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((ranges_ch.valid && ranges_ch.ready)
                || (entries_ch.valid && entries_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: %0d cycles without a handshake, %0d entry words owed",
                         quiet_cycles, expected_q.size());
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus build, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin : run_control
        logic [63:0]      r64;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] pos;
        int               slot;
        int               n_burst;
        int               pick;
        int               k;

        rst_n = 1'b0;

        // --- directed part, starting from an empty table ---
        add_word(63'd5, 63'd4);                 // reversed, table empty
        add_word(SEQ_TOP, 63'd0);               // reversed, widest spread
        add_word(SEQ_TOP, SEQ_TOP);             // single at the top
        add_word(63'd0, 63'd0);                 // single at the bottom
        add_word(63'd2, 63'd2);                 // one gap from 0: stays apart
        add_word(63'd1, 63'd1);                 // abuts both sides: 0..2
        add_word(SEQ_TOP - 1, SEQ_TOP - 1);     // abuts the top entry from below
        for (k = 0; k < 14; k++)                // fill to TABLE_DEPTH entries
            add_word(SEQ_W'(100 + 2 * k), SEQ_W'(100 + 2 * k));
        add_word(63'd200, 63'd200);             // full table, no neighbour: dropped
        add_word(63'd101, 63'd101);             // full table but merges: accepted
        add_word(63'd0, 63'd1000);              // swallows a run of entries
        add_word(63'd1001, 63'd1001);           // abuts the end of the swallowed run

        // --- random part: clusters in fresh territory, one per slot ---
        // Slot s covers [s<<57, (s+1)<<57), so every cluster starts clean;
        // a sweep across older slots occasionally shrinks the table again.
        total_words = stimulus.size() + RANDOM_WORDS;
        slot = 1;
        while (stimulus.size() < total_words)
        begin
            r64     = {$urandom, $urandom};
            base    = (63'(slot) << 57) | 63'(r64[55:0]);
            n_burst = $urandom_range(6, 20);
            for (k = 0; k < n_burst; k++)
            begin
                pick = $urandom_range(99);
                pos  = base + SEQ_W'($urandom_range(WINDOW));
                if (pick < 8)
                    add_word(pos + 1, pos - SEQ_W'($urandom_range(6)));    // reversed
                else if (pick < 14)
                begin
                    r64 = {$urandom, $urandom};                     // stray single
                    add_word(r64[SEQ_W-1:0], r64[SEQ_W-1:0]);
                end
                else if (pick < 40)
                    add_word(pos, pos + SEQ_W'($urandom_range(1, 4)));
                else
                    add_word(pos, pos);
            end
            pick = $urandom_range(3);
            if (pick <= 1)
                add_word(base, base + SEQ_W'(WINDOW + 5));          // close the cluster
            else if (pick == 2 && slot >= 3)
                add_word(63'(slot - 2) << 57, base + SEQ_W'(WINDOW + 5)); // sweep older slots
            slot = (slot % 60) + 1;
        end
        total_words = stimulus.size();

        // pacing phases split the random part in three; each starts drained
        phase1_at = DIRECTED_WORDS + (total_words - DIRECTED_WORDS) / 3;
        phase2_at = DIRECTED_WORDS + 2 * (total_words - DIRECTED_WORDS) / 3;
        stimulus[DIRECTED_WORDS].wait_drain = 1'b1;
        stimulus[phase1_at].wait_drain      = 1'b1;
        stimulus[phase2_at].wait_drain      = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (words_sent < total_words || expected_q.size() != 0)
            @(posedge clk);
        // let anything stray come out before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d range words: %0d reversed, %0d dropped on a full table, %0d merged",
                 words_sent, n_reversed, n_dropped, n_merged);
        $display("Checked %0d entry words, table peaked at %0d of %0d, over three pacing phases",
                 entries_seen, tbl_peak, TABLE_DEPTH);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== received_range_tracker.f =====
hdl/rrt_pkg.sv
hdl/rrt_in_if.sv
hdl/rrt_out_if.sv
hdl/rrt_ram.sv
hdl/received_range_tracker.sv
tb/sv/received_range_tracker_tb.sv
